[design/eulv_pkg.sv]
package eulv_pkg;

  // Angle and vector formats
  localparam int ANGLE_BITS       = 16;
  localparam int VECTOR_FRAC_BITS = 14;
  localparam int QUARTER_TURN     = 1 << (ANGLE_BITS - 2);
  localparam int TILT_LIMIT       = (89 * (1 << ANGLE_BITS) + 180) / 360;
  localparam int CL_W             = ANGLE_BITS - 1;
  localparam int U_W              = ANGLE_BITS - 1;
  localparam int VEC_W            = VECTOR_FRAC_BITS + 2;
  localparam int FIELD_SH         = 60 - VECTOR_FRAC_BITS;

  // Q30 datapath widths
  localparam int X_W    = 31;
  localparam int X2_W   = 32;
  localparam int T_W    = 31;
  localparam int Q_W    = 32;
  localparam int RCP_W  = 30;
  localparam int RCP_SH = 32;
  localparam int DIV_W  = 8;
  localparam int PROD_W = 2 * (T_W + 1);

  localparam logic [X_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [T_W-1:0] ONE_Q30     = 31'h4000_0000;

  // Series terms, one cell each
  localparam int NTERMS = 6;
  localparam logic [DIV_W-1:0] SERIES_DIV [NTERMS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [RCP_W-1:0] SERIES_RCP [NTERMS] = '{
    RCP_W'((64'd1 << RCP_SH) / 64'd156), RCP_W'((64'd1 << RCP_SH) / 64'd110),
    RCP_W'((64'd1 << RCP_SH) / 64'd72),  RCP_W'((64'd1 << RCP_SH) / 64'd42),
    RCP_W'((64'd1 << RCP_SH) / 64'd20),  RCP_W'((64'd1 << RCP_SH) / 64'd6)
  };

  // Sine lanes: remainder and complement for each angle
  localparam int NLANES    = 6;
  localparam int LN_YAW    = 0;
  localparam int LN_PITCH  = 2;
  localparam int LN_ROLL   = 4;

  // Pipeline depth
  localparam int STG_FRONT = 3;
  localparam int STG_CELL  = 3;
  localparam int STG_BACK  = 6;
  localparam int NSTG      = STG_FRONT + STG_CELL * NTERMS + STG_BACK;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  typedef struct packed {
    quad_t           qy;
    quad_t           qp;
    quad_t           qr;
    logic [CL_W-1:0] pc;
    logic [CL_W-1:0] rc;
  } side_t;

  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [X2_W-1:0] x2;
    logic [T_W-1:0]  t;
  } lane_t;

  typedef struct packed {
    lane_t [NLANES-1:0] lane;
    side_t              side;
  } cell_data_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage3_en_t;

endpackage

[design/eulv_front.sv]
module eulv_front (
  input  logic                                  clk,
  input  eulv_pkg::stage3_en_t                  en,
  input  logic        [eulv_pkg::ANGLE_BITS-1:0] yaw_angle,
  input  logic signed [eulv_pkg::ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [eulv_pkg::ANGLE_BITS-1:0] roll_angle,
  output eulv_pkg::cell_data_t                  dout
);
  import eulv_pkg::*;

  logic [ANGLE_BITS-1:0] pcl, rcl;
  logic [ANGLE_BITS-1:0] ang [3];
  logic [U_W-1:0]        u_next [NLANES];
  side_t                 side_next;

  logic [U_W-1:0]        u_a [NLANES];
  side_t                 side_a;
  logic [U_W+X_W-1:0]    xprod [NLANES];
  logic [X_W-1:0]        x_b [NLANES];
  side_t                 side_b;
  logic [2*X_W-1:0]      sq [NLANES];

  function automatic logic [ANGLE_BITS-1:0] clamp(input logic signed [ANGLE_BITS-1:0] a);
    if (a < -TILT_LIMIT) begin
      clamp = ANGLE_BITS'(-TILT_LIMIT);
    end else if (a > TILT_LIMIT) begin
      clamp = ANGLE_BITS'(TILT_LIMIT);
    end else begin
      clamp = a;
    end
  endfunction

  // Clamp tilt, split each angle into quadrant, remainder and complement
  always_comb begin
    pcl = clamp(pitch_angle);
    rcl = clamp(roll_angle);
    ang[0] = yaw_angle;
    ang[1] = pcl;
    ang[2] = rcl;
    for (int j = 0; j < 3; j++) begin
      u_next[2*j]   = {1'b0, ang[j][ANGLE_BITS-3:0]};
      u_next[2*j+1] = U_W'(QUARTER_TURN) - {1'b0, ang[j][ANGLE_BITS-3:0]};
    end
    side_next.qy = quad_t'(ang[0][ANGLE_BITS-1 -: 2]);
    side_next.qp = quad_t'(ang[1][ANGLE_BITS-1 -: 2]);
    side_next.qr = quad_t'(ang[2][ANGLE_BITS-1 -: 2]);
    side_next.pc = pcl[CL_W-1:0];
    side_next.rc = rcl[CL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      u_a    <= u_next;
      side_a <= side_next;
    end
  end

  // Scale angle units to radians in Q30
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      xprod[i] = u_a[i] * HALF_PI_Q30 + (U_W+X_W)'(QUARTER_TURN / 2);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < NLANES; i++) begin
        x_b[i] <= xprod[i][ANGLE_BITS-2 +: X_W];
      end
      side_b <= side_a;
    end
  end

  // Square the radian value, seed the series with one
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      sq[i] = x_b[i] * x_b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < NLANES; i++) begin
        dout.lane[i].x  <= x_b[i];
        dout.lane[i].x2 <= sq[i][30 +: X2_W];
        dout.lane[i].t  <= ONE_Q30;
      end
      dout.side <= side_b;
    end
  end

endmodule

[design/eulv_cell.sv]
module eulv_cell (
  input  logic                          clk,
  input  eulv_pkg::stage3_en_t          en,
  input  logic [eulv_pkg::DIV_W-1:0]    div,
  input  logic [eulv_pkg::RCP_W-1:0]    rcp,
  input  eulv_pkg::cell_data_t          din,
  output eulv_pkg::cell_data_t          dout
);
  import eulv_pkg::*;

  logic [X2_W+T_W-1:0]    p1 [NLANES];
  cell_data_t             s1;
  logic [Q_W-1:0]         q1 [NLANES];
  logic [Q_W+RCP_W-1:0]   p2 [NLANES];
  cell_data_t             s2;
  logic [Q_W-1:0]         q2 [NLANES];
  logic [RCP_W-1:0]       q0 [NLANES];
  logic [RCP_W+DIV_W-1:0] pk [NLANES];
  logic [Q_W-1:0]         rem [NLANES];
  logic [RCP_W-1:0]       quo [NLANES];
  cell_data_t             dout_next;

  // Product of x squared and running term
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      p1[i] = din.lane[i].x2 * din.lane[i].t;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1 <= din;
      for (int i = 0; i < NLANES; i++) begin
        q1[i] <= p1[i][30 +: Q_W];
      end
    end
  end

  // Estimate quotient by reciprocal multiply
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      p2[i] = q1[i] * rcp;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2 <= s1;
      for (int i = 0; i < NLANES; i++) begin
        q2[i] <= q1[i];
        q0[i] <= p2[i][RCP_SH +: RCP_W];
      end
    end
  end

  // Correct the estimate by one and form the next term
  always_comb begin
    dout_next = s2;
    for (int i = 0; i < NLANES; i++) begin
      pk[i]  = q0[i] * div;
      rem[i] = q2[i] - pk[i][Q_W-1:0];
      quo[i] = q0[i] + RCP_W'(rem[i] >= Q_W'(div));
      dout_next.lane[i].t = ONE_Q30 - T_W'(quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dout <= dout_next;
    end
  end

endmodule

[design/eulv_back.sv]
module eulv_back (
  input  logic                                     clk,
  input  logic        [eulv_pkg::STG_BACK-1:0]     en,
  input  eulv_pkg::cell_data_t                     din,
  output logic signed [eulv_pkg::CL_W-1:0]         pitch_clamped,
  output logic signed [eulv_pkg::CL_W-1:0]         roll_clamped,
  output logic signed [eulv_pkg::VEC_W-1:0]        look_x,
  output logic signed [eulv_pkg::VEC_W-1:0]        look_y,
  output logic signed [eulv_pkg::VEC_W-1:0]        look_z,
  output logic signed [eulv_pkg::VEC_W-1:0]        up_x,
  output logic signed [eulv_pkg::VEC_W-1:0]        up_y,
  output logic signed [eulv_pkg::VEC_W-1:0]        up_z
);
  import eulv_pkg::*;

  logic [X_W+T_W-1:0]      pd [NLANES];
  logic [T_W-1:0]          m_next [NLANES];
  logic [T_W-1:0]          m_d [NLANES];
  side_t                   side_d;

  logic [2*(T_W+1)-1:0]    sc_y, sc_p, sc_r;
  logic signed [T_W:0]     sy_e, cy_e, sp_e, cp_e, sr_e, cr_e;
  side_t                   side_e;

  logic [T_W-1:0]          ma, mb;
  logic [2*T_W-1:0]        mab;
  logic signed [T_W:0]     spcr_next;
  logic signed [PROD_W-1:0] sycp_f, cycp_f, cysr_f, sysr_f, cpcr_f;
  logic signed [T_W:0]     spcr_f, sy_f, cy_f, sp_f;
  side_t                   side_f;

  logic signed [PROD_W-1:0] sycp_g, cycp_g, cysr_g, sysr_g, cpcr_g, sysp_g, cysp_g;
  logic signed [T_W:0]     sp_g;
  side_t                   side_g;

  logic signed [PROD_W-1:0] vx_h, vy_h, vz_h, ux_h, uy_h, uz_h;
  side_t                   side_h;

  function automatic logic [2*(T_W+1)-1:0] map_quad(input quad_t q,
                                                    input logic [T_W-1:0] a,
                                                    input logic [T_W-1:0] b);
    logic [T_W:0] pa, pb, na, nb;
    pa = {1'b0, a};
    pb = {1'b0, b};
    na = (T_W+1)'(0) - pa;
    nb = (T_W+1)'(0) - pb;
    case (q)
      QUAD_I:   map_quad = {pa, pb};
      QUAD_II:  map_quad = {pb, na};
      QUAD_III: map_quad = {na, nb};
      QUAD_IV:  map_quad = {nb, pa};
      default:  map_quad = {pa, pb};
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] to_field(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    r = (mag + (PROD_W'(1) << (FIELD_SH - 1))) >> FIELD_SH;
    if (r > (PROD_W'(1) << VECTOR_FRAC_BITS)) begin
      r = PROD_W'(1) << VECTOR_FRAC_BITS;
    end
    to_field = v[PROD_W-1] ? VEC_W'(PROD_W'(0) - r) : VEC_W'(r);
  endfunction

  // Final series multiply gives the sine, saturated at one
  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      pd[i] = din.lane[i].x * din.lane[i].t;
      m_next[i] = (pd[i][30 +: T_W] > ONE_Q30) ? ONE_Q30 : pd[i][30 +: T_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_d    <= m_next;
      side_d <= din.side;
    end
  end

  // Apply quadrant signs
  always_comb begin
    sc_y = map_quad(side_d.qy, m_d[LN_YAW],   m_d[LN_YAW+1]);
    sc_p = map_quad(side_d.qp, m_d[LN_PITCH], m_d[LN_PITCH+1]);
    sc_r = map_quad(side_d.qr, m_d[LN_ROLL],  m_d[LN_ROLL+1]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sy_e   <= sc_y[2*(T_W+1)-1 -: T_W+1];
      cy_e   <= sc_y[T_W:0];
      sp_e   <= sc_p[2*(T_W+1)-1 -: T_W+1];
      cp_e   <= sc_p[T_W:0];
      sr_e   <= sc_r[2*(T_W+1)-1 -: T_W+1];
      cr_e   <= sc_r[T_W:0];
      side_e <= side_d;
    end
  end

  // First products; sin p cos r truncated to Q30 toward zero
  always_comb begin
    ma  = sp_e[T_W] ? T_W'(-sp_e) : T_W'(sp_e);
    mb  = cr_e[T_W] ? T_W'(-cr_e) : T_W'(cr_e);
    mab = ma * mb;
    spcr_next = (sp_e[T_W] != cr_e[T_W]) ? -$signed({1'b0, mab[30 +: T_W]})
                                         :  $signed({1'b0, mab[30 +: T_W]});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sycp_f <= sy_e * cp_e;
      cycp_f <= cy_e * cp_e;
      cysr_f <= cy_e * sr_e;
      sysr_f <= sy_e * sr_e;
      cpcr_f <= cp_e * cr_e;
      spcr_f <= spcr_next;
      sy_f   <= sy_e;
      cy_f   <= cy_e;
      sp_f   <= sp_e;
      side_f <= side_e;
    end
  end

  // Second products with the truncated term
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sycp_g <= sycp_f;
      cycp_g <= cycp_f;
      cysr_g <= cysr_f;
      sysr_g <= sysr_f;
      cpcr_g <= cpcr_f;
      sysp_g <= sy_f * spcr_f;
      cysp_g <= cy_f * spcr_f;
      sp_g   <= sp_f;
      side_g <= side_f;
    end
  end

  // Combine into Q60 components
  always_ff @(posedge clk) begin
    if (en[4]) begin
      vx_h   <= -sycp_g;
      vy_h   <= cycp_g;
      vz_h   <= PROD_W'(sp_g) <<< 30;
      ux_h   <= cysr_g + sysp_g;
      uy_h   <= sysr_g - cysp_g;
      uz_h   <= cpcr_g;
      side_h <= side_g;
    end
  end

  // Round to the output format and hold for the receiver
  always_ff @(posedge clk) begin
    if (en[5]) begin
      pitch_clamped <= side_h.pc;
      roll_clamped  <= side_h.rc;
      look_x        <= to_field(vx_h);
      look_y        <= to_field(vy_h);
      look_z        <= to_field(vz_h);
      up_x          <= to_field(ux_h);
      up_y          <= to_field(uy_h);
      up_z          <= to_field(uz_h);
    end
  end

endmodule

[design/euler_to_look_up_vectors.sv]
// Camera yaw, pitch and roll to look and up vectors.
// Input channel: in_valid / in_stall with yaw_angle, pitch_angle, roll_angle
// in binary angle units (one full turn is 2^ANGLE_BITS). Output channel:
// out_valid / out_stall with the clamped pitch and roll and the look and up
// vectors in signed Q1.14. A transfer happens when valid is high and stall low.
// Every input transfer yields exactly one output transfer, in order.
// Latency: 27 register stages. Throughput: one item per cycle while the
// output side does not stall, set by the fully pipelined sine datapath
// (three front stages, six series cells of three stages each, six back
// stages).
// When out_stall holds a result, the stages behind it keep advancing until
// they fill; empty stages are squeezed out, so in_stall rises only when the
// whole pipeline holds items. The held result does not change.
// Reset (rst, synchronous) empties the pipeline; the data registers are not reset.
module euler_to_look_up_vectors (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic        [eulv_pkg::ANGLE_BITS-1:0]    yaw_angle,
  input  logic signed [eulv_pkg::ANGLE_BITS-1:0]    pitch_angle,
  input  logic signed [eulv_pkg::ANGLE_BITS-1:0]    roll_angle,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [eulv_pkg::CL_W-1:0]          pitch_clamped,
  output logic signed [eulv_pkg::CL_W-1:0]          roll_clamped,
  output logic signed [eulv_pkg::VEC_W-1:0]         look_x,
  output logic signed [eulv_pkg::VEC_W-1:0]         look_y,
  output logic signed [eulv_pkg::VEC_W-1:0]         look_z,
  output logic signed [eulv_pkg::VEC_W-1:0]         up_x,
  output logic signed [eulv_pkg::VEC_W-1:0]         up_y,
  output logic signed [eulv_pkg::VEC_W-1:0]         up_z
);
  import eulv_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  stage3_en_t      front_en;
  stage3_en_t      cell_en [NTERMS];
  cell_data_t      chain [NTERMS+1];

  // Advance a stage when it is empty or the one ahead advances
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int i = NSTG-2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  // Track occupancy of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];
  assign front_en  = '{s1: adv[0], s2: adv[1], s3: adv[2]};

  eulv_front u_front (
    .clk         (clk),
    .en          (front_en),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .dout        (chain[0])
  );

  // Row of series cells, one term each
  for (genvar c = 0; c < NTERMS; c++) begin : g_cell
    assign cell_en[c] = '{s1: adv[STG_FRONT + STG_CELL*c],
                          s2: adv[STG_FRONT + STG_CELL*c + 1],
                          s3: adv[STG_FRONT + STG_CELL*c + 2]};
    eulv_cell u_cell (
      .clk  (clk),
      .en   (cell_en[c]),
      .div  (SERIES_DIV[c]),
      .rcp  (SERIES_RCP[c]),
      .din  (chain[c]),
      .dout (chain[c+1])
    );
  end

  eulv_back u_back (
    .clk           (clk),
    .en            (adv[NSTG-STG_BACK +: STG_BACK]),
    .din           (chain[NTERMS]),
    .pitch_clamped (pitch_clamped),
    .roll_clamped  (roll_clamped),
    .look_x        (look_x),
    .look_y        (look_y),
    .look_z        (look_z),
    .up_x          (up_x),
    .up_y          (up_y),
    .up_z          (up_z)
  );

  // Input side stalls only behind a full, stalled pipeline
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld && out_stall))
    else $error("input stalled with room in the pipeline");

  // An accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted item lost at entry");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vld[NSTG-2]) |=> !out_valid)
    else $error("result repeated after transfer");

endmodule
